// ===== hw/rtl/stdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdd_pkg
// Shared types and constants of the sine table dual duty generator.
// ----------------------------------------------------------------------------
package stdd_pkg;

    // default sizes of the sample table
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int SAMPLE_WIDTH_DEF = 11;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int INDEX_W    = 8;
    localparam int VALUE_W    = 11;
    localparam int GAIN_W     = 11;
    localparam int DIVISOR_W  = 10;
    localparam int LENGTH_W   = 9;
    localparam int OFFSET_W   = 8;
    localparam int POS_W      = 9;
    localparam int DUTY_W     = 12;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // output levels
    localparam int MID_LEVEL = 500;
    localparam int DUTY_MAX  = 4095;

    // register reset values
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 10'd512;
    localparam logic [LENGTH_W-1:0]  LENGTH_RESET  = 9'd256;

    // request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SYNC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_OFFSET = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// ===== hw/rtl/sine_table_dual_duty_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_table_dual_duty_generator_top
// Steps through a table of sine samples and scales each one into two
// saturated duty levels, with a sync level and a clip flag.
// ----------------------------------------------------------------------------
// A tick word passes the READ, SETUP, DIVIDE and FINISH states, with the
// two-bit-per-cycle restoring dividers working in DIVIDE; FINISH loads the
// result word once the output is free, and the next word is taken back in
// IDLE, where sync and table write words are taken without leaving it.
// Reset clears the step index, the sequencer and the configuration registers
// to reset values; the sample table is not cleared and must be written first.
module sine_table_dual_duty_generator_top #(
    parameter int TABLE_DEPTH  = stdd_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = stdd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index[7:0], entry_value[18:8], zero pad
    input  logic [stdd_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [stdd_pkg::REQ_W-1:0]       s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // duty_a[11:0], duty_b[23:12], sync_level[24], clipped[25], zero pad
    output logic [stdd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stdd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int PROD_W  = SAMPLE_WIDTH + stdd_pkg::GAIN_W;
    localparam int MAG_W   = SAMPLE_WIDTH + stdd_pkg::GAIN_W - 1;
    localparam int ITER    = (MAG_W + 1) / 2;
    localparam int DIV_W   = 2 * ITER;
    localparam int CNT_W   = $clog2(ITER + 1);
    localparam int LVL_W   = MAG_W + 2;
    localparam int LEN_CAP = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;
    localparam int DV_W    = stdd_pkg::DIVISOR_W;
    localparam int P_W     = stdd_pkg::POS_W;
    localparam int D_W     = stdd_pkg::DUTY_W;

    // configuration registers
    logic signed [stdd_pkg::GAIN_W-1:0]   gain_a_reg;
    logic signed [stdd_pkg::GAIN_W-1:0]   gain_b_reg;
    logic        [DV_W-1:0]               divisor_reg;
    logic        [stdd_pkg::LENGTH_W-1:0] length_reg;
    logic        [stdd_pkg::OFFSET_W-1:0] sync_offset_reg;
    logic        [P_W-1:0]                pulse_offset_reg;

    // sequencer and step state
    stdd_pkg::state_t state_reg, state_next;
    logic [P_W-1:0]   step_reg;
    logic [CNT_W-1:0] count_reg;
    logic             sync_level_reg;

    // sample table
    logic [SAMPLE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [SAMPLE_WIDTH-1:0] rdata_reg;

    // datapath registers
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic                     neg_a_reg, neg_b_reg;
    logic [DIV_W-1:0]         dvd_a_reg, dvd_b_reg;
    logic [DV_W-1:0]          rem_a_reg, rem_b_reg;
    logic [DV_W-1:0]          divisor_eff_reg;

    // output register
    localparam int OUT_DATA_W_L = stdd_pkg::OUT_DATA_W;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W_L-1:0]   m_tdata_reg;

    // combinational signals
    logic                     in_accept;
    logic                     out_load;
    logic                     is_tick, is_sync, is_write;
    logic [stdd_pkg::INDEX_W-1:0] entry_index;
    logic signed [stdd_pkg::VALUE_W-1:0] entry_value;
    logic [P_W-1:0]           len_eff;
    logic [P_W-1:0]           pos_wrapped;
    logic [DV_W-1:0]          divisor_eff;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [PROD_W-1:0] prod_a_c, prod_b_c;
    logic [DV_W+DIV_W-1:0]    step_a, step_b;
    logic [D_W:0]             res_a, res_b;

    // two restoring division steps: returns remainder and shifted dividend
    function automatic logic [DV_W+DIV_W-1:0] div_step2(
        input logic [DV_W-1:0]  rem_in,
        input logic [DIV_W-1:0] dvd_in,
        input logic [DV_W-1:0]  d
    );
        logic [DV_W-1:0]  rem;
        logic [DIV_W-1:0] dvd;
        logic [DV_W:0]    trial;
        rem = rem_in;
        dvd = dvd_in;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem, dvd[DIV_W-1]};
            dvd   = {dvd[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                rem    = DV_W'(trial - {1'b0, d});
                dvd[0] = 1'b1;
            end
            else
            begin
                rem = DV_W'(trial);
            end
        end
        return {rem, dvd};
    endfunction

    // apply sign, add MID_LEVEL and saturate: returns clip flag and level
    function automatic logic [D_W:0] finish_level(
        input logic [MAG_W-1:0] quot,
        input logic             neg
    );
        logic signed [LVL_W-1:0] q;
        logic signed [LVL_W-1:0] lv;
        logic [D_W:0]            r;
        q  = LVL_W'(quot);
        lv = LVL_W'(stdd_pkg::MID_LEVEL) + (neg ? -q : q);
        if (lv < 0)
            r = {1'b1, D_W'(0)};
        else if (lv > LVL_W'(stdd_pkg::DUTY_MAX))
            r = {1'b1, D_W'(stdd_pkg::DUTY_MAX)};
        else
            r = {1'b0, D_W'(lv)};
        return r;
    endfunction

    // input word decode
    assign entry_index = s_tdata[stdd_pkg::INDEX_W-1:0];
    assign entry_value = s_tdata[stdd_pkg::INDEX_W +: stdd_pkg::VALUE_W];
    assign is_tick     = (s_tuser == stdd_pkg::REQ_TICK);
    assign is_sync     = (s_tuser == stdd_pkg::REQ_SYNC);
    assign is_write    = (s_tuser == stdd_pkg::REQ_WRITE);
    assign in_accept   = s_tvalid && s_tready;

    // effective length, wrapped step index and effective divisor
    always_comb
    begin
        if (length_reg == '0)
            len_eff = P_W'(1);
        else if (int'(length_reg) > TABLE_DEPTH)
            len_eff = P_W'(LEN_CAP);
        else
            len_eff = P_W'(length_reg);
        pos_wrapped = (step_reg >= len_eff) ? '0 : step_reg;
        divisor_eff = (divisor_reg == '0) ? DV_W'(1) : divisor_reg;
    end

    // sample read back and products
    assign sample   = rdata_reg;
    assign prod_a_c = PROD_W'(gain_a_reg) * PROD_W'(sample);
    assign prod_b_c = PROD_W'(gain_b_reg) * PROD_W'(sample);

    // divider steps and final levels
    assign step_a = div_step2(rem_a_reg, dvd_a_reg, divisor_eff_reg);
    assign step_b = div_step2(rem_b_reg, dvd_b_reg, divisor_eff_reg);
    assign res_a  = finish_level(dvd_a_reg[MAG_W-1:0], neg_a_reg);
    assign res_b  = finish_level(dvd_b_reg[MAG_W-1:0], neg_b_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stdd_pkg::ST_IDLE:
            begin
                if (in_accept && is_tick)
                    state_next = stdd_pkg::ST_READ;
            end
            stdd_pkg::ST_READ:
                state_next = stdd_pkg::ST_SETUP;
            stdd_pkg::ST_SETUP:
                state_next = stdd_pkg::ST_DIVIDE;
            stdd_pkg::ST_DIVIDE:
            begin
                if (count_reg == '0)
                    state_next = stdd_pkg::ST_FINISH;
            end
            stdd_pkg::ST_FINISH:
            begin
                if (out_load)
                    state_next = stdd_pkg::ST_IDLE;
            end
            default:
                state_next = stdd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            stdd_pkg::ST_IDLE:
                s_tready = 1'b1;
            stdd_pkg::ST_FINISH:
                out_load = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stdd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_a_reg       <= '0;
            gain_b_reg       <= '0;
            divisor_reg      <= stdd_pkg::DIVISOR_RESET;
            length_reg       <= stdd_pkg::LENGTH_RESET;
            sync_offset_reg  <= '0;
            pulse_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                stdd_pkg::CFG_GAIN_A:       gain_a_reg       <= cfg_data;
                stdd_pkg::CFG_GAIN_B:       gain_b_reg       <= cfg_data;
                stdd_pkg::CFG_DIVISOR:      divisor_reg      <= cfg_data[DV_W-1:0];
                stdd_pkg::CFG_TABLE_LENGTH: length_reg       <= cfg_data[stdd_pkg::LENGTH_W-1:0];
                stdd_pkg::CFG_SYNC_OFFSET:  sync_offset_reg  <= cfg_data[stdd_pkg::OFFSET_W-1:0];
                stdd_pkg::CFG_PULSE_OFFSET: pulse_offset_reg <= cfg_data[P_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // step index: reload on sync, advance on tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (in_accept && is_sync)
            step_reg <= P_W'(sync_offset_reg);
        else if (in_accept && is_tick)
            step_reg <= pos_wrapped + P_W'(1);
    end

    // sample table: write port for table words, read port for ticks
    always_ff @(posedge clk)
    begin
        if (in_accept && is_write && (int'(entry_index) < TABLE_DEPTH))
            mem[ADDR_W'(entry_index)] <= SAMPLE_WIDTH'(entry_value);
        if (in_accept && is_tick)
            rdata_reg <= mem[ADDR_W'(pos_wrapped)];
    end

    // datapath: sync level, divisor, products, magnitudes, iterations
    always_ff @(posedge clk)
    begin
        if (in_accept && is_tick)
        begin
            sync_level_reg  <= !(pos_wrapped >= pulse_offset_reg);
            divisor_eff_reg <= divisor_eff;
        end
        case (state_reg)
            stdd_pkg::ST_READ:
            begin
                prod_a_reg <= prod_a_c;
                prod_b_reg <= prod_b_c;
            end
            stdd_pkg::ST_SETUP:
            begin
                neg_a_reg <= prod_a_reg[PROD_W-1];
                neg_b_reg <= prod_b_reg[PROD_W-1];
                dvd_a_reg <= DIV_W'(MAG_W'(prod_a_reg[PROD_W-1] ? -prod_a_reg : prod_a_reg));
                dvd_b_reg <= DIV_W'(MAG_W'(prod_b_reg[PROD_W-1] ? -prod_b_reg : prod_b_reg));
                rem_a_reg <= '0;
                rem_b_reg <= '0;
                count_reg <= CNT_W'(ITER - 1);
            end
            stdd_pkg::ST_DIVIDE:
            begin
                {rem_a_reg, dvd_a_reg} <= step_a;
                {rem_b_reg, dvd_b_reg} <= step_b;
                count_reg <= count_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= OUT_DATA_W_L'({res_a[D_W] || res_b[D_W], sync_level_reg,
                                          res_b[D_W-1:0], res_a[D_W-1:0]});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/stdd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdd_checker
// Port-level checks of the sine table dual duty generator, bound to the top.
// ----------------------------------------------------------------------------
module stdd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [stdd_pkg::REQ_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stdd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a tick occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == stdd_pkg::REQ_TICK) |=> !s_tready)
        else $error("input taken while a tick is in progress");

    // sync, table and other non-tick words leave the input ready
    a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != stdd_pkg::REQ_TICK) |=> s_tready)
        else $error("non-tick word held the input");

    // a new result word only ends a busy spell
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready) && s_tready)
        else $error("result word without a tick in progress");

endmodule

bind sine_table_dual_duty_generator_top stdd_checker u_stdd_checker (.*);
